// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define GLZ_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
`define GLZ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define GLZ_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define GLZ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/core/glz_pkg.sv =====
// ----------------------------------------------------------------------------
// glz_pkg
// Types, constants and helpers shared by the GIF LZW compressor.
// ----------------------------------------------------------------------------
`default_nettype none
package glz_pkg;
	localparam int CODE_W    = 12;
	localparam int PIX_W     = 8;
	localparam int PB_W      = 4;
	localparam int EPOCH_W   = 8;
	localparam int ACC_W     = 19;
	localparam int CNT_W     = 5;
	localparam logic [3:0] MAX_WIDTH = 4'd12;
	localparam logic [3:0] MIN_CODE_SIZE = 4'd3;
	localparam logic [3:0] RESET_PIXEL_BITS = 4'd8;
	localparam logic [2:0] ADDR_PIXEL_BITS = 3'd0;

	typedef struct packed {
		logic                valid;
		logic [CODE_W-1:0]   value;
		logic [3:0]          width;
		logic                flush;
	} code_req_t;

	typedef struct packed {
		logic [EPOCH_W-1:0]  epoch;
		logic [CODE_W-1:0]   prefix;
		logic [PIX_W-1:0]    ch;
		logic [CODE_W-1:0]   code;
	} slot_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_START_CLR,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_EMIT_PREFIX,
		ST_EMIT_CLR,
		ST_FIN_CODE,
		ST_FIN_END
	} ctrl_state_t;

	function automatic logic [3:0] code_size_of(logic [3:0] pb);
		logic [3:0] p;
		p = pb;
		if (p < 4'd1) p = 4'd1;
		if (p > 4'd8) p = 4'd8;
		return ((p + 4'd1) < MIN_CODE_SIZE) ? MIN_CODE_SIZE : p + 4'd1;
	endfunction

	function automatic logic [8:0] root_count_of(logic [3:0] rb);
		return 9'(9'd1 << (rb - 4'd1));
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/glz_pix_if.sv =====
// ----------------------------------------------------------------------------
// glz_pix_if
// Pixel channel: valid/ready with pixel index and last-pixel mark.
// ----------------------------------------------------------------------------
`default_nettype none
interface glz_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       final_pixel;
	modport source (output valid, output pixel, output final_pixel, input ready);
	modport sink   (input valid, input pixel, input final_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/glz_byte_if.sv =====
// ----------------------------------------------------------------------------
// glz_byte_if
// Code byte channel: valid/ready with packed byte and end-of-stream mark.
// ----------------------------------------------------------------------------
`default_nettype none
interface glz_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;
	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/glz_hash_ram.sv =====
// ----------------------------------------------------------------------------
// glz_hash_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module glz_hash_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/glz_packer.sv =====
// ----------------------------------------------------------------------------
// glz_packer
// Packs variable-width codes LSB first into bytes behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module glz_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  glz_pkg::code_req_t req,
	output logic              req_ready,
	glz_byte_if.source        bytes
);
	import glz_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             flush_q;
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic             olast_q;

	logic             slot_free;
	logic             drain;
	logic [ACC_W-1:0] code_bits;

	assign req_ready = (cnt_q < CNT_W'(8)) && !flush_q;
	assign slot_free = !ovalid_q || bytes.ready;
	assign drain     = slot_free && ((cnt_q >= CNT_W'(8)) || (flush_q && cnt_q != '0));
	assign code_bits = ACC_W'(req.value & CODE_W'((13'd1 << req.width) - 13'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			flush_q  <= 1'b0;
			ovalid_q <= 1'b0;
			obyte_q  <= '0;
			olast_q  <= 1'b0;
		end else begin
			if (req.valid && req_ready) begin
				acc_q   <= acc_q | (code_bits << cnt_q);
				cnt_q   <= cnt_q + CNT_W'(req.width);
				flush_q <= req.flush;
			end else if (drain) begin
				acc_q   <= acc_q >> 8;
				cnt_q   <= (cnt_q >= CNT_W'(8)) ? cnt_q - CNT_W'(8) : '0;
				// final byte of the stream once no more than a byte remains
				if (flush_q && cnt_q <= CNT_W'(8)) begin
					flush_q <= 1'b0;
				end
			end
			if (drain) begin
				ovalid_q <= 1'b1;
				obyte_q  <= acc_q[7:0];
				olast_q  <= flush_q && (cnt_q <= CNT_W'(8));
			end else if (bytes.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign bytes.valid     = ovalid_q;
	assign bytes.out_byte  = obyte_q;
	assign bytes.last_byte = olast_q;
endmodule
`default_nettype wire

// ===== rtl/core/glz_ctrl.sv =====
// ----------------------------------------------------------------------------
// glz_ctrl
// LZW sequencer: hashed dictionary probe, insert and code issue per pixel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module glz_ctrl #(
	parameter int DICT_CODES = 4096,
	parameter int MAX_STRING = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         pixel_bits,
	glz_pix_if.sink            pix,
	output glz_pkg::code_req_t req,
	input  logic               req_ready
);
	import glz_pkg::*;

	localparam int SLOTS = 2 * DICT_CODES;
	localparam int HB    = $clog2(SLOTS);
	localparam int NC_W  = $clog2(DICT_CODES + 1);
	localparam int LEN_W = $clog2(MAX_STRING + 1);

	ctrl_state_t state_q, state_d;

	logic               started_q;
	logic [3:0]         root_bits_q;
	logic [NC_W-1:0]    next_code_q;
	logic [3:0]         width_q;
	logic [CODE_W-1:0]  cur_q;
	logic [LEN_W-1:0]   len_q;
	logic [PIX_W-1:0]   pix_q;
	logic               fin_q;
	logic               cap_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_pend_q;
	logic [HB-1:0]      sweep_addr_q;
	logic [HB-1:0]      probe_addr_q;

	logic               ram_we, ram_re;
	logic [HB-1:0]      ram_waddr;
	slot_t              ram_wdata;
	logic [$bits(slot_t)-1:0] ram_rdata;
	slot_t              slot;

	logic               accept;
	logic [3:0]         new_root;
	logic [8:0]         root_cnt;
	logic [PIX_W-1:0]   pix_masked;
	logic [LEN_W+1:0]   len_chk;
	logic [23:0]        hash_mix;
	logic               live, key_hit;
	logic [NC_W-1:0]    nc_inc;
	logic [13:0]        width_pow;

	glz_hash_ram #(.DEPTH(SLOTS), .WIDTH($bits(slot_t))) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (probe_addr_q),
		.rdata (ram_rdata)
	);

	assign slot       = slot_t'(ram_rdata);
	assign accept     = pix.valid && pix.ready;
	assign new_root   = code_size_of(pixel_bits);
	assign root_cnt   = root_count_of(root_bits_q);
	assign pix_masked = pix.pixel & PIX_W'(root_count_of(started_q ? root_bits_q : new_root)
		- 9'd1);
	assign len_chk    = (LEN_W+2)'(len_q) + (LEN_W+2)'(3);
	assign hash_mix   = (24'(cur_q) << 1) ^ (24'(pix_masked) << (HB - 8));
	assign live       = slot.epoch == epoch_q;
	assign key_hit    = live && !cap_q && slot.prefix == cur_q && slot.ch == pix_q;
	assign nc_inc     = next_code_q + NC_W'(1);
	assign width_pow  = 14'(14'd1 << width_q);

	always_comb begin
		state_d   = state_q;
		pix.ready = (state_q == ST_IDLE) && !sweep_pend_q;
		req       = '0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = probe_addr_q;
		ram_wdata = '{epoch: epoch_q, prefix: cur_q, ch: pix_q,
			code: CODE_W'(next_code_q)};
		unique case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_addr_q;
				ram_wdata = '0;
				if (sweep_addr_q == HB'(SLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (sweep_pend_q) begin
					state_d = ST_SWEEP;
				end else if (accept) begin
					state_d = started_q ? ST_PROBE_RD : ST_START_CLR;
				end
			end
			ST_START_CLR: begin
				req = '{valid: 1'b1, value: CODE_W'(root_cnt), width: width_q, flush: 1'b0};
				if (req_ready) state_d = fin_q ? ST_FIN_CODE : ST_IDLE;
			end
			ST_PROBE_RD: begin
				ram_re  = 1'b1;
				state_d = ST_PROBE_CHK;
			end
			ST_PROBE_CHK: begin
				priority if (!live) begin
					state_d = ST_EMIT_PREFIX;
				end else if (key_hit) begin
					state_d = fin_q ? ST_FIN_CODE : ST_IDLE;
				end else begin
					state_d = ST_PROBE_RD;
				end
			end
			ST_EMIT_PREFIX: begin
				req = '{valid: 1'b1, value: cur_q, width: width_q, flush: 1'b0};
				if (req_ready) begin
					ram_we = 1'b1;
					if (next_code_q == NC_W'(DICT_CODES - 1)) state_d = ST_EMIT_CLR;
					else state_d = fin_q ? ST_FIN_CODE : ST_IDLE;
				end
			end
			ST_EMIT_CLR: begin
				req = '{valid: 1'b1, value: CODE_W'(root_cnt), width: width_q, flush: 1'b0};
				if (req_ready) state_d = fin_q ? ST_FIN_CODE : ST_IDLE;
			end
			ST_FIN_CODE: begin
				req = '{valid: 1'b1, value: cur_q, width: width_q, flush: 1'b0};
				if (req_ready) state_d = ST_FIN_END;
			end
			ST_FIN_END: begin
				req = '{valid: 1'b1, value: CODE_W'(root_cnt + 9'd1), width: width_q,
					flush: 1'b1};
				if (req_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			root_bits_q  <= code_size_of(RESET_PIXEL_BITS);
			next_code_q  <= NC_W'(root_count_of(code_size_of(RESET_PIXEL_BITS))) + NC_W'(2);
			width_q      <= code_size_of(RESET_PIXEL_BITS);
			cur_q        <= '0;
			len_q        <= '0;
			pix_q        <= '0;
			fin_q        <= 1'b0;
			cap_q        <= 1'b0;
			epoch_q      <= EPOCH_W'(1);
			sweep_pend_q <= 1'b1;
			sweep_addr_q <= '0;
			probe_addr_q <= '0;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					sweep_addr_q <= sweep_addr_q + HB'(1);
					if (sweep_addr_q == HB'(SLOTS - 1)) sweep_pend_q <= 1'b0;
				end
				ST_IDLE: begin
					if (accept) begin
						fin_q <= pix.final_pixel;
						pix_q <= pix_masked;
						if (!started_q) begin
							// open a stream: latch code size, fresh table
							root_bits_q <= new_root;
							next_code_q <= NC_W'(root_count_of(new_root)) + NC_W'(2);
							width_q     <= new_root;
							cur_q       <= CODE_W'(pix_masked);
							len_q       <= LEN_W'(1);
							started_q   <= 1'b1;
							if (epoch_q == '1) begin
								epoch_q      <= EPOCH_W'(1);
								sweep_pend_q <= 1'b1;
							end else begin
								epoch_q <= epoch_q + EPOCH_W'(1);
							end
						end else begin
							cap_q        <= len_chk > (LEN_W+2)'(MAX_STRING);
							probe_addr_q <= hash_mix[HB-1:0];
						end
					end
				end
				ST_PROBE_CHK: begin
					if (live && key_hit) begin
						cur_q <= slot.code;
						len_q <= len_q + LEN_W'(1);
					end else if (live) begin
						probe_addr_q <= probe_addr_q + HB'(1);
					end
				end
				ST_EMIT_PREFIX: begin
					if (req_ready) begin
						next_code_q <= nc_inc;
						if (14'(nc_inc) > width_pow && width_q < MAX_WIDTH) begin
							width_q <= width_q + 4'd1;
						end
						cur_q <= CODE_W'(pix_q);
						len_q <= LEN_W'(1);
					end
				end
				ST_EMIT_CLR: begin
					if (req_ready) begin
						next_code_q <= NC_W'(root_cnt) + NC_W'(2);
						width_q     <= root_bits_q;
						if (epoch_q == '1) begin
							epoch_q      <= EPOCH_W'(1);
							sweep_pend_q <= 1'b1;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
						end
					end
				end
				ST_FIN_END: begin
					if (req_ready) begin
						started_q   <= 1'b0;
						cur_q       <= '0;
						len_q       <= '0;
						next_code_q <= NC_W'(root_cnt) + NC_W'(2);
						width_q     <= root_bits_q;
						if (epoch_q == '1) begin
							epoch_q      <= EPOCH_W'(1);
							sweep_pend_q <= 1'b1;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	`GLZ_ASSERT_IMPLY(a_write_state, clk, arst_n, ram_we, (state_q == ST_EMIT_PREFIX || state_q == ST_SWEEP), "table write outside insert or sweep")
	`GLZ_ASSERT_ALWAYS(a_epoch_nonzero, clk, arst_n, epoch_q != '0, "epoch zero collides with swept slots")
	`GLZ_ASSERT_IMPLY(a_hit_code, clk, arst_n, (state_q == ST_PROBE_CHK && key_hit), (NC_W'(slot.code) < next_code_q && slot.code >= CODE_W'(root_cnt) + CODE_W'(2)), "hit on code outside live range")
	`GLZ_ASSERT_ALWAYS(a_width_range, clk, arst_n, (width_q >= MIN_CODE_SIZE && width_q <= MAX_WIDTH), "code width out of range")
endmodule
`default_nettype wire

// ===== rtl/core/gif_lzw_compressor.sv =====
// The first code of a pixel is issued in the cycle after its transfer on a stream
// start, from START_CLR; on a miss it is issued from EMIT_PREFIX after PROBE_RD and
// PROBE_CHK; its bytes leave the output register after the packer takes the code.
// A pixel that hits at the first slot passes PROBE_RD and PROBE_CHK, which repeat per
// extra hash probe (one read-port access each); a new pixel is taken only in IDLE.
// Reset: asynchronous, active low; a sweep over all 2*DICT_CODES slots then clears
// the hash table before the first pixel, and again once every 255 table resets.
// ----------------------------------------------------------------------------
// gif_lzw_compressor
// GIF LZW encoder: pixel indices in, LSB-first packed code bytes out.
// ----------------------------------------------------------------------------
`default_nettype none
module gif_lzw_compressor #(
	parameter int DICT_CODES = 4096,
	parameter int MAX_STRING = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	glz_pix_if.sink     pix,
	glz_byte_if.source  bytes
);
	import glz_pkg::*;

	logic [PB_W-1:0] pixel_bits_q;
	code_req_t       req;
	logic            req_ready;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PIXEL_BITS) ? 32'(pixel_bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_bits_q <= RESET_PIXEL_BITS;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_PIXEL_BITS) begin
			pixel_bits_q <= pwdata[PB_W-1:0];
		end
	end

	glz_ctrl #(.DICT_CODES(DICT_CODES), .MAX_STRING(MAX_STRING)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_bits (pixel_bits_q),
		.pix        (pix),
		.req        (req),
		.req_ready  (req_ready)
	);

	glz_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_ready (req_ready),
		.bytes     (bytes)
	);
endmodule
`default_nettype wire

// ===== tb/tb_gif_lzw_compressor.sv =====
// ----------------------------------------------------------------------------
// tb_gif_lzw_compressor
// Drives pixel streams and pixel_bits settings into the LZW compressor, models
// the code stream and its byte packing, and checks every output byte in order.
// ----------------------------------------------------------------------------
`default_nettype none

class lzw_scoreboard;
	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_t;

	byte_t      pending[$];
	int         errors;
	logic [3:0] pixel_bits;
	int         code_size;
	int         next_code;
	int         width;
	int         cur_code;
	int         str_len;
	int         bit_buf;
	int         bit_cnt;
	bit         in_stream;
	int         dict[int];

	function new();
		errors = 0;
		pixel_bits = glz_pkg::RESET_PIXEL_BITS;
		code_size = size_for(pixel_bits);
		in_stream = 0;
		cur_code = 0;
		str_len = 0;
		bit_buf = 0;
		bit_cnt = 0;
		restart_table();
	endfunction

	function int size_for(int pb);
		if (pb < 1) pb = 1;
		if (pb > 8) pb = 8;
		return (pb + 1 < 3) ? 3 : pb + 1;
	endfunction

	function int roots();
		return 1 << (code_size - 1);
	endfunction

	function void restart_table();
		next_code = roots() + 2;
		width = code_size;
		dict.delete();
	endfunction

	function void push(int b);
		byte_t e;
		e.data = b[7:0];
		e.last = 1'b0;
		pending.push_back(e);
	endfunction

	function void pack_code(int code, int w);
		int acc;
		int n;
		acc = bit_buf | ((code & ((1 << w) - 1)) << bit_cnt);
		n = bit_cnt + w;
		while (n >= 8) begin
			push(acc);
			acc = acc >> 8;
			n -= 8;
		end
		bit_buf = acc & 8'hFF;
		bit_cnt = n;
	endfunction

	function void note_pixel(logic [7:0] pixel, logic final_pixel);
		int pix;
		int key;
		int added;
		int before_cnt;
		before_cnt = pending.size();
		if (!in_stream) begin
			code_size = size_for(pixel_bits);
			restart_table();
			pack_code(roots(), width);
			cur_code = pixel & (roots() - 1);
			str_len = 1;
			in_stream = 1;
		end else begin
			pix = pixel & (roots() - 1);
			key = cur_code * 256 + pix;
			if (str_len + 3 <= 256 && dict.exists(key)) begin
				cur_code = dict[key];
				str_len++;
			end else begin
				pack_code(cur_code, width);
				added = next_code;
				// keep the lowest code on a duplicate
				if (added < 4096 && !dict.exists(key)) dict[key] = added;
				next_code++;
				if (next_code > (1 << width) && width < 12) width++;
				if (added >= 4095) begin
					pack_code(roots(), width);
					restart_table();
				end
				cur_code = pix;
				str_len = 1;
			end
		end
		if (final_pixel) begin
			pack_code(cur_code, width);
			pack_code(roots() + 1, width);
			if (bit_cnt != 0) begin
				push(bit_buf);
				bit_buf = 0;
				bit_cnt = 0;
			end
			if (pending.size() > before_cnt) pending[pending.size() - 1].last = 1'b1;
			in_stream = 0;
			cur_code = 0;
			str_len = 0;
			restart_table();
		end
	endfunction

	function void check_byte(logic [7:0] data, logic last);
		byte_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected byte %h last %b", data, last);
			return;
		end
		e = pending.pop_front();
		if (data !== e.data || last !== e.last) begin
			errors++;
			if (errors <= 10)
				$display("byte mismatch: expected %h last %b, got %h last %b",
					e.data, e.last, data, last);
		end
	endfunction
endclass

module tb_gif_lzw_compressor;
	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          idle_mode;
	int          hold_cycles;
	lzw_scoreboard sb;

	glz_pix_if  pix ();
	glz_byte_if bytes ();

	gif_lzw_compressor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix.sink),
		.bytes   (bytes.source)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: hold off on request, else stall per idle mode
	initial begin
		bytes.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				bytes.ready <= 1'b0;
			end else if (idle_mode == 2 || idle_mode == 3) begin
				bytes.ready <= ($urandom_range(99) >= (idle_mode == 2 ? 88 : 27));
			end else begin
				bytes.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && bytes.valid && bytes.ready) sb.check_byte(bytes.out_byte, bytes.last_byte);
	end

	task automatic send_pixel(input logic [7:0] p, input logic fin);
		int pct;
		pct = (idle_mode == 1) ? 88 : (idle_mode == 3) ? 27 : 0;
		if (pct > 0 && $urandom_range(99) < pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < pct) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel <= p;
		pix.final_pixel <= fin;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		sb.note_pixel(p, fin);
	endtask

	task automatic drain();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		// no-output pixels may still be in flight
		repeat (200) @(posedge clk);
	endtask

	task automatic write_pixel_bits(input logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= glz_pkg::ADDR_PIXEL_BITS;
		pwdata <= {28'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.pixel_bits = v;
		@(posedge clk);
	endtask

	task automatic random_stream(input int len, input int alphabet);
		int i;
		for (i = 0; i < len; i++)
			send_pixel(alphabet > 0 ? 8'($urandom_range(alphabet - 1)) : 8'($urandom),
				i == len - 1);
	endtask

	initial begin
		int n;
		int k;
		logic [3:0] settings[6];
		sb = new();
		idle_mode = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix.valid = 1'b0;
		pix.pixel = '0;
		pix.final_pixel = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, extremes, single-pixel stream
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd170, 1'b1);
		drain();
		write_pixel_bits(4'd1);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h02, 1'b0);
		send_pixel(8'hFF, 1'b0);
		send_pixel(8'h03, 1'b1);
		drain();
		write_pixel_bits(4'd0);
		send_pixel(8'd5, 1'b0);
		send_pixel(8'd5, 1'b0);
		send_pixel(8'd5, 1'b0);
		drain();
		// change mid-stream: applies to the next stream only
		write_pixel_bits(4'd15);
		send_pixel(8'd7, 1'b1);
		send_pixel(8'h80, 1'b0);
		send_pixel(8'h7F, 1'b0);
		send_pixel(8'h80, 1'b1);
		drain();

		// random streams under each idle mode
		settings = '{4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd7};
		for (idle_mode = 0; idle_mode < 4; idle_mode++) begin
			for (k = 0; k < 3; k++) begin
				write_pixel_bits(settings[$urandom_range(5)]);
				n = $urandom_range(1, 24);
				random_stream(n, $urandom_range(1) ? 0 : $urandom_range(1, 4));
				drain();
			end
		end

		// long receiver hold while pixels keep coming
		idle_mode = 0;
		hold_cycles = 400;
		random_stream(40, 0);
		drain();

		idle_mode = 3;
		write_pixel_bits(4'd6);
		random_stream(20, 3);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/glz_pkg.sv
rtl/core/glz_pix_if.sv
rtl/core/glz_byte_if.sv
rtl/core/glz_hash_ram.sv
rtl/core/glz_packer.sv
rtl/core/glz_ctrl.sv
rtl/core/gif_lzw_compressor.sv
tb/tb_gif_lzw_compressor.sv
